### rtl/core/srfr_pkg.sv
// shared types and constants for the servo ramp block
`timescale 1ns / 1ps

package srfr_pkg;

  // pulse limits in microseconds
  localparam logic [11:0] PULSE_MAX      = 12'd4095;
  localparam logic [11:0] PULSE_RESET    = 12'd1500;
  localparam logic [11:0] SAFE_LOW       = 12'd800;
  localparam logic [11:0] SAFE_HIGH_FAST = 12'd2300;
  localparam logic [11:0] SAFE_HIGH_SLOW = 12'd2251;
  // saturation value of the power term
  localparam logic [12:0] POW_SAT        = 13'd4096;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_THROWN_PULSE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOSED_PULSE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_STEP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_DELAY   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOW_MOTION  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FROG_ENABLE  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FROG_INVERT  = 3'd6;

  typedef struct packed {
    logic        want_thrown;
    logic [2:0]  channel;
    logic [31:0] now_ms;
    logic [3:0]  servos_moving;
    logic [2:0]  speed_multiplier;
  } srfr_in_t;

  typedef struct packed {
    logic        servo_write;
    logic [11:0] servo_pulse_us;
    logic        frog_write;
    logic        frog_on;
    logic [2:0]  out_channel;
    logic        move_complete;
  } srfr_out_t;

  typedef struct packed {
    logic load;
    logic pow_step;
    logic commit;
  } srfr_cmd_t;

  typedef struct packed {
    logic pow_done;
    logic out_free;
  } srfr_sts_t;

endpackage

### rtl/core/srfr_ctrl.sv
// sequencing state machine for the servo ramp block
`timescale 1ns / 1ps

module srfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  srfr_pkg::srfr_sts_t sts_i,
  output srfr_pkg::srfr_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POW  = 3'b010,
    S_FIN  = 3'b100
  } srfr_state_t;

  srfr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = S_POW;
        end
      end
      S_POW: begin
        if (sts_i.pow_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd_o.pow_step = 1'b1;
        end
      end
      S_FIN: begin
        // wait for the output register to drain
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load |=> (state_r == S_POW))
    else $error("load did not start the power loop");

endmodule

### rtl/core/srfr_dp.sv
// datapath: config registers, power loop, ramp step and output register
`timescale 1ns / 1ps

module srfr_dp #(
  parameter int SERVO_CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  srfr_pkg::srfr_in_t                   in_data,
  input  logic                                 cfg_we,
  input  logic [srfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [srfr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  srfr_pkg::srfr_cmd_t                  cmd_i,
  output srfr_pkg::srfr_sts_t                  sts_o,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output srfr_pkg::srfr_out_t                  out_data
);

  // configuration
  logic [11:0] thrown_r, closed_r, base_r;
  logic [15:0] delay_r;
  logic        slow_r, frog_en_r, frog_inv_r;

  // per-transfer working registers
  srfr_pkg::srfr_in_t in_r;
  logic        elapsed_ok_r;
  logic [12:0] p_r;
  logic [2:0]  rem_r;
  logic [11:0] st_r;

  // turnout state
  logic [11:0] cur_pulse_r, cur_pulse_nxt;
  logic        never_moved_r, never_moved_nxt;
  logic [31:0] last_step_r, last_step_nxt;

  logic               out_valid_r;
  srfr_pkg::srfr_out_t out_r, out_nxt;

  logic [16:0] prod;
  logic [13:0] st_sum;
  logic [11:0] st_nxt;
  logic [31:0] elapsed;
  logic [11:0] target, diff, moved;
  logic        chan_ok, up, reach, safe_fast, safe_slow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thrown_r   <= srfr_pkg::PULSE_RESET;
      closed_r   <= srfr_pkg::PULSE_RESET;
      base_r     <= 12'd1;
      delay_r    <= '0;
      slow_r     <= 1'b0;
      frog_en_r  <= 1'b0;
      frog_inv_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        srfr_pkg::REG_THROWN_PULSE: thrown_r   <= cfg_wdata[11:0];
        srfr_pkg::REG_CLOSED_PULSE: closed_r   <= cfg_wdata[11:0];
        srfr_pkg::REG_BASE_STEP:    base_r     <= cfg_wdata[11:0];
        srfr_pkg::REG_STEP_DELAY:   delay_r    <= cfg_wdata;
        srfr_pkg::REG_SLOW_MOTION:  slow_r     <= cfg_wdata[0];
        srfr_pkg::REG_FROG_ENABLE:  frog_en_r  <= cfg_wdata[0];
        srfr_pkg::REG_FROG_INVERT:  frog_inv_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // power loop: one 13x4 multiply per step, saturating at 4096
  assign prod    = 17'(p_r) * 17'(in_r.servos_moving);
  assign elapsed = in_data.now_ms - last_step_r;
  assign st_sum  = 14'(p_r) + 14'(base_r);
  assign st_nxt  = (st_sum > 14'(srfr_pkg::PULSE_MAX)) ? srfr_pkg::PULSE_MAX : st_sum[11:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (cmd_i.load) begin
      rem_r <= in_data.speed_multiplier;
    end else if (cmd_i.pow_step) begin
      rem_r <= rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (cmd_i.load) begin
      in_r         <= in_data;
      p_r          <= {9'd0, in_data.servos_moving};
      elapsed_ok_r <= (elapsed >= {16'd0, delay_r});
    end else if (cmd_i.pow_step) begin
      p_r <= (prod > 17'(srfr_pkg::PULSE_MAX)) ? srfr_pkg::POW_SAT : prod[12:0];
    end
  end

  // ramp step
  assign target    = in_r.want_thrown ? thrown_r : closed_r;
  assign chan_ok   = {1'b0, in_r.channel} < 4'(SERVO_CHANNELS);
  assign up        = target > cur_pulse_r;
  assign diff      = up ? (target - cur_pulse_r) : (cur_pulse_r - target);
  assign reach     = diff <= st_r;
  assign moved     = up ? (cur_pulse_r + st_r) : (cur_pulse_r - st_r);
  assign safe_fast = (target > srfr_pkg::SAFE_LOW) && (target < srfr_pkg::SAFE_HIGH_FAST);
  assign safe_slow = (target > srfr_pkg::SAFE_LOW) && (target < srfr_pkg::SAFE_HIGH_SLOW);

  always_comb begin
    cur_pulse_nxt   = cur_pulse_r;
    never_moved_nxt = never_moved_r;
    last_step_nxt   = last_step_r;
    out_nxt         = '0;
    if (chan_ok) begin
      if (!slow_r) begin
        if ((target != cur_pulse_r) || never_moved_r) begin
          out_nxt.servo_write = safe_fast;
          out_nxt.frog_write  = frog_en_r;
          out_nxt.frog_on     = frog_en_r & (in_r.want_thrown ^ frog_inv_r);
          cur_pulse_nxt       = target;
          never_moved_nxt     = 1'b0;
        end
      end else if ((target != cur_pulse_r) && elapsed_ok_r) begin
        last_step_nxt = in_r.now_ms;
        if (safe_slow) begin
          cur_pulse_nxt         = reach ? target : moved;
          out_nxt.servo_write   = 1'b1;
          out_nxt.move_complete = reach;
          if (reach) begin
            never_moved_nxt = 1'b0;
          end
          out_nxt.frog_write = reach & frog_en_r;
          out_nxt.frog_on    = reach & frog_en_r & (in_r.want_thrown ^ frog_inv_r);
        end
      end
    end
    out_nxt.servo_pulse_us = cur_pulse_nxt;
    out_nxt.out_channel    = in_r.channel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pulse_r   <= srfr_pkg::PULSE_RESET;
      never_moved_r <= 1'b1;
      last_step_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        cur_pulse_r   <= cur_pulse_nxt;
        never_moved_r <= never_moved_nxt;
        last_step_r   <= last_step_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      out_r <= out_nxt;
    end
  end

  assign sts_o.pow_done = (rem_r == 3'd0);
  assign sts_o.out_free = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.commit |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken transfer");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.pow_step |-> (rem_r != 3'd0))
    else $error("power step past the exponent count");

  assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd_i.commit && rst_n) |=> ($stable(cur_pulse_r) && $stable(last_step_r)))
    else $error("turnout state changed without a commit");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.commit |=> out_valid_r)
    else $error("commit did not present a result");

endmodule

### rtl/core/servo_ramp_with_frog_relay_unit.sv
// Turnout servo slew-rate limiter with frog polarity relay. Each input transfer is one service
// call for a servo channel and yields exactly one result transfer. After acceptance the
// datapath raises servos_moving to the power speed_multiplier+1 with one 13x4 multiply per
// cycle, then computes the ramp step and commits the result once the output register is free.
// A finished result sits in an output register, so the next call is accepted while it waits.
// The user must write configuration registers through the cfg_ port only while no call is in
// flight; the block itself does not enforce this. No clearing pass after reset.
`timescale 1ns / 1ps

module servo_ramp_with_frog_relay_unit #(
  parameter int SERVO_CHANNELS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  srfr_pkg::srfr_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output srfr_pkg::srfr_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [srfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  srfr_pkg::srfr_cmd_t cmd;
  srfr_pkg::srfr_sts_t sts;

  srfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  srfr_dp #(
    .SERVO_CHANNELS (SERVO_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### bench/servo_ramp_with_frog_relay_unit_tb.sv
// self-checking testbench for the turnout servo ramp and frog relay unit
`timescale 1ns / 1ps

module servo_ramp_with_frog_relay_unit_tb;

  localparam int NUM_CHANNELS = 8;
  localparam int RAND_PHASES  = 24;
  localparam int PHASE_CALLS  = 53;
  localparam int SETTLE_CYCLES = 12;
  localparam int STUCK_LIMIT  = 2000;
  // index past the end of the register list, writes must be dropped
  localparam logic [srfr_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  srfr_pkg::srfr_in_t               in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  srfr_pkg::srfr_out_t              out_data;
  logic                             cfg_we = 1'b0;
  logic [srfr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [srfr_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  servo_ramp_with_frog_relay_unit #(
    .SERVO_CHANNELS(NUM_CHANNELS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // register copies
  logic [11:0] m_thrown = srfr_pkg::PULSE_RESET;
  logic [11:0] m_closed = srfr_pkg::PULSE_RESET;
  logic [11:0] m_base_step = 12'd1;
  logic [15:0] m_delay = 16'd0;
  logic        m_slow = 1'b0;
  logic        m_frog_en = 1'b0;
  logic        m_frog_inv = 1'b0;
  // servo state copies
  logic [11:0] m_pulse = srfr_pkg::PULSE_RESET;
  logic        m_fresh = 1'b1;
  logic [31:0] m_last_step = 32'd0;

  srfr_pkg::srfr_in_t  call_q[$];
  srfr_pkg::srfr_out_t due_results[$];
  int        pushed_total = 0;
  int        checked_total = 0;
  int        mismatch_count = 0;
  int        slow_steps = 0;
  int        moves_done = 0;
  int        settings_used = 0;
  bit        in_idle = 1'b1;
  bit        out_idle = 1'b1;
  int        drv_wait = 0;
  int        rcv_wait = 0;
  int        stuck_cycles = 0;

  // base step plus count^(mult+1), power term saturating above the pulse range
  function automatic logic [11:0] ramp_step(input logic [3:0] cnt, input logic [2:0] mult);
    int unsigned p;
    p = 32'(cnt);
    for (int i = 0; i < mult; i++) begin
      p = p * cnt;
      if (p > srfr_pkg::PULSE_MAX) p = 32'(srfr_pkg::POW_SAT);
    end
    p = p + 32'(m_base_step);
    if (p > srfr_pkg::PULSE_MAX) p = 32'(srfr_pkg::PULSE_MAX);
    return p[11:0];
  endfunction

  function automatic srfr_pkg::srfr_out_t servo_tick(input srfr_pkg::srfr_in_t c);
    srfr_pkg::srfr_out_t r;
    logic [11:0] target;
    logic [31:0] elapsed;
    int unsigned st, cur, tgt, nxt;
    r = '0;
    target = c.want_thrown ? m_thrown : m_closed;
    elapsed = c.now_ms - m_last_step;
    if (c.channel < NUM_CHANNELS) begin
      if (!m_slow) begin
        if (target != m_pulse || m_fresh) begin
          if (target > srfr_pkg::SAFE_LOW && target < srfr_pkg::SAFE_HIGH_FAST) begin
            r.servo_write = 1'b1;
          end
          if (m_frog_en) begin
            r.frog_write = 1'b1;
            r.frog_on = c.want_thrown ^ m_frog_inv;
          end
          m_pulse = target;
          m_fresh = 1'b0;
        end
      end else if (target != m_pulse && elapsed >= m_delay) begin
        st = 32'(ramp_step(c.servos_moving, c.speed_multiplier));
        m_last_step = c.now_ms;
        if (target > srfr_pkg::SAFE_LOW && target < srfr_pkg::SAFE_HIGH_SLOW) begin
          cur = 32'(m_pulse);
          tgt = 32'(target);
          if (tgt > cur) nxt = (tgt - cur <= st) ? tgt : cur + st;
          else nxt = (cur - tgt <= st) ? tgt : cur - st;
          m_pulse = nxt[11:0];
          r.servo_write = 1'b1;
          slow_steps++;
          if (nxt == tgt) begin
            r.move_complete = 1'b1;
            m_fresh = 1'b0;
            moves_done++;
          end
        end
        if (r.move_complete && m_frog_en) begin
          r.frog_write = 1'b1;
          r.frog_on = c.want_thrown ^ m_frog_inv;
        end
      end
    end
    r.servo_pulse_us = m_pulse;
    r.out_channel = c.channel;
    return r;
  endfunction

  task automatic set_reg(input logic [srfr_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [srfr_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      srfr_pkg::REG_THROWN_PULSE: m_thrown = val[11:0];
      srfr_pkg::REG_CLOSED_PULSE: m_closed = val[11:0];
      srfr_pkg::REG_BASE_STEP:    m_base_step = val[11:0];
      srfr_pkg::REG_STEP_DELAY:   m_delay = val;
      srfr_pkg::REG_SLOW_MOTION:  m_slow = val[0];
      srfr_pkg::REG_FROG_ENABLE:  m_frog_en = val[0];
      srfr_pkg::REG_FROG_INVERT:  m_frog_inv = val[0];
      default: ;
    endcase
  endtask

  task automatic queue_call(input logic want, input logic [2:0] chan, input logic [31:0] now,
                            input logic [3:0] cnt, input logic [2:0] mult);
    srfr_pkg::srfr_in_t c;
    c.want_thrown = want;
    c.channel = chan;
    c.now_ms = now;
    c.servos_moving = cnt;
    c.speed_multiplier = mult;
    call_q.push_back(c);
    pushed_total++;
  endtask

  // block is idle once every queued call has come back
  task automatic drain();
    while (checked_total != pushed_total) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [15:0] pick_pulse();
    logic [11:0] v;
    case ($urandom_range(0, 9))
      0: v = 12'd0;
      1: v = srfr_pkg::PULSE_MAX;
      2: v = srfr_pkg::SAFE_LOW;
      3: v = srfr_pkg::SAFE_LOW + 12'd1;
      4: v = srfr_pkg::SAFE_HIGH_SLOW - 12'd1;
      5: v = srfr_pkg::SAFE_HIGH_SLOW;
      6: v = srfr_pkg::SAFE_HIGH_FAST - 12'd1;
      7: v = srfr_pkg::SAFE_HIGH_FAST;
      default: v = 12'($urandom_range(801, 2250));
    endcase
    // junk in the bits above the register width
    return {4'($urandom_range(0, 15)), v};
  endfunction

  // driver
  always @(posedge clk) begin
    logic hold;
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_wait = 0;
    end else begin
      hold = in_valid;
      if (in_valid && in_ready) begin
        due_results.push_back(servo_tick(in_data));
        hold = 1'b0;
        drv_wait = in_idle ? int'($urandom_range(0, 11)) : 0;
      end
      if (!hold) begin
        if (drv_wait > 0) drv_wait--;
        else if (call_q.size() > 0) begin
          in_data <= call_q.pop_front();
          hold = 1'b1;
        end
      end
      in_valid <= hold;
    end
  end

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    srfr_pkg::srfr_out_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rcv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
          mismatch_count++;
        end else begin
          exp_r = due_results.pop_front();
          check_field("servo_write", 32'(exp_r.servo_write), 32'(out_data.servo_write));
          check_field("servo_pulse_us", 32'(exp_r.servo_pulse_us),
                      32'(out_data.servo_pulse_us));
          check_field("frog_write", 32'(exp_r.frog_write), 32'(out_data.frog_write));
          check_field("frog_on", 32'(exp_r.frog_on), 32'(out_data.frog_on));
          check_field("out_channel", 32'(exp_r.out_channel), 32'(out_data.out_channel));
          check_field("move_complete", 32'(exp_r.move_complete),
                      32'(out_data.move_complete));
          checked_total++;
        end
        rcv_wait = out_idle ? int'($urandom_range(0, 11)) : 0;
      end
      if (rcv_wait > 0) begin
        rcv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: no transfer for too long while calls are outstanding
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || checked_total == pushed_total)
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
        $display("servo_ramp_with_frog_relay_unit_tb failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] clock_ms;
    logic        want;
    logic [2:0]  chan;
    int          n, run_len, span;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first call after reset writes even though the target equals the stored pulse
    queue_call(1'b0, 3'd0, 32'd0, 4'd0, 3'd0);
    queue_call(1'b0, 3'd7, 32'd1, 4'd15, 3'd7);
    drain();
    set_reg(srfr_pkg::REG_THROWN_PULSE, 16'hF8FB);
    set_reg(srfr_pkg::REG_CLOSED_PULSE, 16'd801);
    set_reg(srfr_pkg::REG_FROG_ENABLE, 16'd1);
    queue_call(1'b1, 3'd1, 32'd2, 4'd1, 3'd0);
    queue_call(1'b0, 3'd2, 32'd3, 4'd2, 3'd1);
    queue_call(1'b0, 3'd3, 32'd4, 4'd3, 3'd2);
    drain();
    set_reg(srfr_pkg::REG_FROG_INVERT, 16'd1);
    set_reg(REG_UNUSED, 16'hFFFF);
    queue_call(1'b1, 3'd4, 32'd5, 4'd4, 3'd3);
    drain();
    // unsafe targets still get stored and drive the frog
    set_reg(srfr_pkg::REG_THROWN_PULSE, 16'd2300);
    set_reg(srfr_pkg::REG_CLOSED_PULSE, 16'd800);
    queue_call(1'b1, 3'd5, 32'd6, 4'd5, 3'd4);
    queue_call(1'b0, 3'd6, 32'd7, 4'd6, 3'd5);
    drain();
    set_reg(srfr_pkg::REG_THROWN_PULSE, 16'hFFFF);
    set_reg(srfr_pkg::REG_CLOSED_PULSE, 16'd0);
    queue_call(1'b1, 3'd7, 32'hFFFF_FFFF, 4'd7, 3'd6);
    queue_call(1'b0, 3'd0, 32'd8, 4'd8, 3'd7);
    drain();
    // slow ramp: delay gating, full jump, hold at target, partial steps
    set_reg(srfr_pkg::REG_SLOW_MOTION, 16'd1);
    set_reg(srfr_pkg::REG_THROWN_PULSE, 16'd2250);
    set_reg(srfr_pkg::REG_CLOSED_PULSE, 16'd801);
    set_reg(srfr_pkg::REG_BASE_STEP, 16'd1);
    set_reg(srfr_pkg::REG_STEP_DELAY, 16'd10);
    set_reg(srfr_pkg::REG_FROG_INVERT, 16'd0);
    queue_call(1'b1, 3'd1, 32'd5, 4'd15, 3'd7);
    queue_call(1'b1, 3'd1, 32'd20, 4'd15, 3'd7);
    queue_call(1'b1, 3'd1, 32'd40, 4'd15, 3'd7);
    queue_call(1'b0, 3'd2, 32'd25, 4'd2, 3'd1);
    queue_call(1'b0, 3'd2, 32'd30, 4'd2, 3'd1);
    queue_call(1'b0, 3'd2, 32'd40, 4'd0, 3'd0);
    drain();
    // zero-size step
    set_reg(srfr_pkg::REG_BASE_STEP, 16'd0);
    queue_call(1'b0, 3'd3, 32'd50, 4'd0, 3'd5);
    drain();
    // unsafe slow target across the time wrap
    set_reg(srfr_pkg::REG_THROWN_PULSE, 16'd2251);
    queue_call(1'b1, 3'd4, 32'hFFFF_FFF0, 4'd9, 3'd2);
    queue_call(1'b1, 3'd4, 32'd5, 4'd9, 3'd2);
    drain();
    set_reg(srfr_pkg::REG_STEP_DELAY, 16'hFFFF);
    set_reg(srfr_pkg::REG_BASE_STEP, 16'hFFFF);
    queue_call(1'b0, 3'd5, 32'd6, 4'd1, 3'd0);
    queue_call(1'b0, 3'd5, 32'h0001_0004, 4'd1, 3'd0);
    drain();

    clock_ms = 32'd0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_reg(srfr_pkg::REG_THROWN_PULSE, pick_pulse());
      set_reg(srfr_pkg::REG_CLOSED_PULSE, pick_pulse());
      case ($urandom_range(0, 3))
        0: set_reg(srfr_pkg::REG_BASE_STEP, 16'd0);
        1: set_reg(srfr_pkg::REG_BASE_STEP, 16'hFFFF);
        2: set_reg(srfr_pkg::REG_BASE_STEP, 16'($urandom_range(0, 65535)));
        default: set_reg(srfr_pkg::REG_BASE_STEP, 16'($urandom_range(1, 40)));
      endcase
      case ($urandom_range(0, 4))
        0: set_reg(srfr_pkg::REG_STEP_DELAY, 16'd0);
        1: set_reg(srfr_pkg::REG_STEP_DELAY, 16'hFFFF);
        2: set_reg(srfr_pkg::REG_STEP_DELAY, 16'($urandom_range(0, 65535)));
        default: set_reg(srfr_pkg::REG_STEP_DELAY, 16'($urandom_range(0, 20)));
      endcase
      set_reg(srfr_pkg::REG_SLOW_MOTION, ($urandom_range(0, 9) < 7) ? 16'd1 : 16'd0);
      set_reg(srfr_pkg::REG_FROG_ENABLE, 16'($urandom_range(0, 65535)));
      set_reg(srfr_pkg::REG_FROG_INVERT, 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 3) == 0) set_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
      in_idle = (ph % 4) != 3;
      out_idle = (ph % 5) != 4;
      if (ph == 5) clock_ms = 32'hFFFF_0000;
      span = int'(m_delay) + int'(m_delay) / 2 + 2;
      n = 0;
      while (n < PHASE_CALLS) begin
        if ($urandom_range(0, 99) < 85) begin
          // hold one request long enough for the ramp to get somewhere
          run_len = int'($urandom_range(3, 12));
          want = 1'($urandom_range(0, 1));
          chan = 3'($urandom_range(0, 7));
          for (int k = 0; k < run_len; k++) begin
            clock_ms = clock_ms + $urandom_range(0, span);
            queue_call(want, chan, clock_ms, 4'($urandom_range(0, 15)),
                       3'($urandom_range(0, 7)));
            n++;
          end
        end else begin
          queue_call(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom(),
                     4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
          n++;
        end
      end
      drain();
    end

    $display("covered %0d service calls over %0d register settings", checked_total,
             settings_used);
    $display("slow steps taken: %0d, moves completed: %0d", slow_steps, moves_done);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("servo_ramp_with_frog_relay_unit_tb passed");
    end else begin
      $display("servo_ramp_with_frog_relay_unit_tb failed");
    end
    $finish;
  end

endmodule
